// ===== sv/mgt_pkg.sv =====
// Shared types and constants for the motion gesture tracker.
// No dependencies; used by the channel interfaces and all modules.
package mgt_pkg;

	localparam int ACC_W    = 16;
	localparam int VAL_W    = 17;
	localparam int COUNT_W  = 8;
	localparam int CFG_W    = 17;
	localparam int NUM_REGS = 8;
	localparam int IDX_W    = 3;
	localparam int MAG_W    = 17;

	localparam logic [IDX_W-1:0] REG_THR_XY  = 3'd0;
	localparam logic [IDX_W-1:0] REG_THR_Z   = 3'd1;
	localparam logic [IDX_W-1:0] REG_LO_XY   = 3'd2;
	localparam logic [IDX_W-1:0] REG_HI_XY   = 3'd3;
	localparam logic [IDX_W-1:0] REG_LO_Z    = 3'd4;
	localparam logic [IDX_W-1:0] REG_HI_Z    = 3'd5;
	localparam logic [IDX_W-1:0] REG_GAIN    = 3'd6;
	localparam logic [IDX_W-1:0] REG_Z_OFS   = 3'd7;

	localparam logic [15:0] THR_XY_RST = 16'd835;
	localparam logic [15:0] THR_Z_RST  = 16'd668;
	localparam logic [16:0] LO_RST     = 17'h1F97A;
	localparam logic [16:0] HI_RST     = 17'd1670;
	localparam logic [15:0] GAIN_RST   = 16'd256;

	localparam logic [MAG_W-1:0] GESTURE_STRONG = 17'd50;
	localparam logic [MAG_W-1:0] GESTURE_QUIET  = 17'd10;

	typedef struct packed {
		logic [15:0]      thr;
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;
		logic [15:0]      gain;
	} axis_cfg_t;

	function automatic logic [MAG_W-1:0] mag(input logic signed [MAG_W-1:0] v);
		mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

endpackage

// ===== sv/mgt_ifs.sv =====
// Valid/ready channels for sample beats in and result beats out.
// Depends on mgt_pkg for field widths.
interface mgt_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [mgt_pkg::ACC_W-1:0]    accel_x;
	logic signed [mgt_pkg::ACC_W-1:0]    accel_y;
	logic signed [mgt_pkg::ACC_W-1:0]    accel_z;

	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface mgt_result_if;
	logic                                valid;
	logic                                ready;
	logic signed [mgt_pkg::COUNT_W-1:0]  count_x;
	logic signed [mgt_pkg::COUNT_W-1:0]  count_y;
	logic signed [mgt_pkg::COUNT_W-1:0]  count_z;
	logic                                moving_x;
	logic                                moving_y;
	logic                                moving_z;
	logic                                gesture_z;
	logic                                gesture_x;
	logic                                gesture_y;

	modport source (output valid, count_x, count_y, count_z, moving_x, moving_y, moving_z,
		gesture_z, gesture_x, gesture_y, input ready);
	modport sink (input valid, count_x, count_y, count_z, moving_x, moving_y, moving_z,
		gesture_z, gesture_x, gesture_y, output ready);
endinterface

// ===== sv/mgt_axis.sv =====
// Per-axis motion counter update: change, threshold, gain step, rest decay, clamp.
// Purely combinational; depends on mgt_pkg.
module mgt_axis #(
	parameter int COUNT_LIMIT = 100
) (
	input  logic signed [mgt_pkg::VAL_W-1:0]                 val,
	input  logic signed [mgt_pkg::VAL_W-1:0]                 last,
	input  logic signed [$clog2(COUNT_LIMIT+1):0]            cnt,
	input  logic                                             flag,
	input  mgt_pkg::axis_cfg_t                               cfg,
	output logic signed [$clog2(COUNT_LIMIT+1):0]            cnt_next,
	output logic                                             flag_next
);
	localparam int CW    = $clog2(COUNT_LIMIT + 1) + 1;
	localparam int DW    = mgt_pkg::VAL_W + 1;
	localparam int PW    = DW + 17;
	localparam int IW    = PW - 8;
	localparam int SUM_W = IW + 1;
	localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(COUNT_LIMIT);
	localparam logic signed [SUM_W-1:0] LIM_LO = -SUM_W'(COUNT_LIMIT);

	logic signed [DW-1:0]    d;
	logic [DW-1:0]           mag_d;
	logic                    over;
	logic signed [16:0]      gain_s;
	logic signed [PW-1:0]    prod;
	logic signed [PW-1:0]    prod_adj;
	logic signed [IW-1:0]    inc;
	logic signed [SUM_W-1:0] sum;
	logic signed [CW-1:0]    sum_clamped;
	logic signed [CW-1:0]    cnt_dec;
	logic                    at_rest;

	assign d       = DW'(val) - DW'(last);
	assign mag_d   = d[DW-1] ? DW'(-d) : DW'(d);
	assign over    = mag_d > DW'(cfg.thr);
	assign gain_s  = $signed({1'b0, cfg.gain});
	assign prod    = PW'(d) * PW'(gain_s);
	// round toward zero on the divide by 256
	assign prod_adj = prod[PW-1] ? prod + PW'(255) : prod;
	assign inc     = prod_adj[PW-1:8];
	assign sum     = SUM_W'(inc) + SUM_W'(cnt);
	assign at_rest = (val > $signed(cfg.lo)) && (val < $signed(cfg.hi));

	always_comb begin
		if (sum > LIM_HI) begin
			sum_clamped = CW'(LIM_HI);
		end else if (sum < LIM_LO) begin
			sum_clamped = CW'(LIM_LO);
		end else begin
			sum_clamped = sum[CW-1:0];
		end
	end

	always_comb begin
		if (cnt > 0) begin
			cnt_dec = cnt - CW'(1);
		end else if (cnt < 0) begin
			cnt_dec = cnt + CW'(1);
		end else begin
			cnt_dec = cnt;
		end
	end

	always_comb begin
		if (over) begin
			cnt_next  = sum_clamped;
			flag_next = 1'b1;
		end else if (at_rest) begin
			cnt_next  = cnt_dec;
			flag_next = 1'b0;
		end else begin
			cnt_next  = cnt;
			flag_next = flag;
		end
	end

endmodule

// ===== sv/motion_gesture_tracker.sv =====
// Motion gesture tracker: three-axis motion counters with isolated-gesture pulses.
// Path: sample beat to result beat through the input register and then the result register.
// Throughput: one sample per cycle while result beats are taken; state advances in one pass.
// Reset (arst_n low, asynchronous): counters, flags, last samples cleared, registers to defaults.
// Depends on mgt_pkg, mgt_ifs and mgt_axis.
module motion_gesture_tracker #(
	parameter int COUNT_LIMIT = 100
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mgt_pkg::IDX_W-1:0]        cfg_index,
	input  logic [mgt_pkg::CFG_W-1:0]        cfg_data,
	mgt_sample_if.sink                       sample,
	mgt_result_if.source                     result
);
	localparam int CW = $clog2(COUNT_LIMIT + 1) + 1;
	localparam int VW = mgt_pkg::VAL_W;
	localparam int MW = mgt_pkg::MAG_W;

	logic [15:0]   thr_xy_q, thr_z_q, gain_q, z_ofs_q;
	logic [15:0]   lo_xy_q, hi_xy_q;
	logic [VW-1:0] lo_z_q, hi_z_q;

	logic                                s1_valid;
	logic signed [mgt_pkg::ACC_W-1:0]    x_s1, y_s1, z_s1;
	logic                                res_valid_q;
	logic                                adv;

	logic signed [mgt_pkg::ACC_W-1:0] last_x_q, last_y_q;
	logic signed [VW-1:0]             last_z_q;
	logic signed [CW-1:0]             cnt_x_q, cnt_y_q, cnt_z_q;
	logic                             flag_x_q, flag_y_q, flag_z_q;

	logic signed [VW-1:0]   x_v, y_v, z_v;
	mgt_pkg::axis_cfg_t     cfg_xy, cfg_z;
	logic signed [CW-1:0]   nx, ny, nz, x1, y1, z1;
	logic                   fx, fy, fz;
	logic                   gz, gx, gy;

	logic signed [mgt_pkg::COUNT_W-1:0] count_x_s2, count_y_s2, count_z_s2;
	logic moving_x_s2, moving_y_s2, moving_z_s2;
	logic gesture_z_s2, gesture_x_s2, gesture_y_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_xy_q <= mgt_pkg::THR_XY_RST;
			thr_z_q  <= mgt_pkg::THR_Z_RST;
			lo_xy_q  <= mgt_pkg::LO_RST[15:0];
			hi_xy_q  <= mgt_pkg::HI_RST[15:0];
			lo_z_q   <= mgt_pkg::LO_RST;
			hi_z_q   <= mgt_pkg::HI_RST;
			gain_q   <= mgt_pkg::GAIN_RST;
			z_ofs_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				mgt_pkg::REG_THR_XY: thr_xy_q <= cfg_data[15:0];
				mgt_pkg::REG_THR_Z:  thr_z_q  <= cfg_data[15:0];
				mgt_pkg::REG_LO_XY:  lo_xy_q  <= cfg_data[15:0];
				mgt_pkg::REG_HI_XY:  hi_xy_q  <= cfg_data[15:0];
				mgt_pkg::REG_LO_Z:   lo_z_q   <= cfg_data;
				mgt_pkg::REG_HI_Z:   hi_z_q   <= cfg_data;
				mgt_pkg::REG_GAIN:   gain_q   <= cfg_data[15:0];
				mgt_pkg::REG_Z_OFS:  z_ofs_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign adv          = !res_valid_q || result.ready;
	assign sample.ready = !s1_valid || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (sample.ready) begin
			s1_valid <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			x_s1 <= sample.accel_x;
			y_s1 <= sample.accel_y;
			z_s1 <= sample.accel_z;
		end
	end

	assign x_v = VW'(x_s1);
	assign y_v = VW'(y_s1);
	assign z_v = VW'(z_s1) - VW'($signed(z_ofs_q));

	assign cfg_xy = '{thr: thr_xy_q, lo: VW'($signed(lo_xy_q)), hi: VW'($signed(hi_xy_q)),
		gain: gain_q};
	assign cfg_z  = '{thr: thr_z_q, lo: lo_z_q, hi: hi_z_q, gain: gain_q};

	mgt_axis #(.COUNT_LIMIT(COUNT_LIMIT)) u_axis_x (
		.val(x_v), .last(VW'(last_x_q)), .cnt(cnt_x_q), .flag(flag_x_q), .cfg(cfg_xy),
		.cnt_next(nx), .flag_next(fx)
	);

	mgt_axis #(.COUNT_LIMIT(COUNT_LIMIT)) u_axis_y (
		.val(y_v), .last(VW'(last_y_q)), .cnt(cnt_y_q), .flag(flag_y_q), .cfg(cfg_xy),
		.cnt_next(ny), .flag_next(fy)
	);

	mgt_axis #(.COUNT_LIMIT(COUNT_LIMIT)) u_axis_z (
		.val(z_v), .last(last_z_q), .cnt(cnt_z_q), .flag(flag_z_q), .cfg(cfg_z),
		.cnt_next(nz), .flag_next(fz)
	);

	// gesture checks in order Z, X, Y; later checks see earlier clears
	always_comb begin
		gz = (mgt_pkg::mag(MW'(nz)) > mgt_pkg::GESTURE_STRONG)
			&& (mgt_pkg::mag(MW'(nx)) < mgt_pkg::GESTURE_QUIET)
			&& (mgt_pkg::mag(MW'(ny)) < mgt_pkg::GESTURE_QUIET);
		z1 = gz ? '0 : nz;
		gx = (mgt_pkg::mag(MW'(nx)) > mgt_pkg::GESTURE_STRONG)
			&& (mgt_pkg::mag(MW'(ny)) < mgt_pkg::GESTURE_QUIET)
			&& (mgt_pkg::mag(MW'(z1)) < mgt_pkg::GESTURE_QUIET);
		x1 = gx ? '0 : nx;
		gy = (mgt_pkg::mag(MW'(ny)) > mgt_pkg::GESTURE_STRONG)
			&& (mgt_pkg::mag(MW'(x1)) < mgt_pkg::GESTURE_QUIET)
			&& (mgt_pkg::mag(MW'(z1)) < mgt_pkg::GESTURE_QUIET);
		y1 = gy ? '0 : ny;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			last_z_q    <= '0;
			cnt_x_q     <= '0;
			cnt_y_q     <= '0;
			cnt_z_q     <= '0;
			flag_x_q    <= 1'b0;
			flag_y_q    <= 1'b0;
			flag_z_q    <= 1'b0;
		end else if (adv) begin
			res_valid_q <= s1_valid;
			if (s1_valid) begin
				last_x_q <= x_s1;
				last_y_q <= y_s1;
				last_z_q <= z_v;
				cnt_x_q  <= x1;
				cnt_y_q  <= y1;
				cnt_z_q  <= z1;
				flag_x_q <= fx;
				flag_y_q <= fy;
				flag_z_q <= fz;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_valid) begin
			count_x_s2   <= mgt_pkg::COUNT_W'(MW'(x1));
			count_y_s2   <= mgt_pkg::COUNT_W'(MW'(y1));
			count_z_s2   <= mgt_pkg::COUNT_W'(MW'(z1));
			moving_x_s2  <= fx;
			moving_y_s2  <= fy;
			moving_z_s2  <= fz;
			gesture_z_s2 <= gz;
			gesture_x_s2 <= gx;
			gesture_y_s2 <= gy;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.count_x   = count_x_s2;
	assign result.count_y   = count_y_s2;
	assign result.count_z   = count_z_s2;
	assign result.moving_x  = moving_x_s2;
	assign result.moving_y  = moving_y_s2;
	assign result.moving_z  = moving_z_s2;
	assign result.gesture_z = gesture_z_s2;
	assign result.gesture_x = gesture_x_s2;
	assign result.gesture_y = gesture_y_s2;

`ifndef SYNTHESIS
	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_x_q <= CW'(COUNT_LIMIT)) && (cnt_x_q >= -CW'(COUNT_LIMIT))
		&& (cnt_y_q <= CW'(COUNT_LIMIT)) && (cnt_y_q >= -CW'(COUNT_LIMIT))
		&& (cnt_z_q <= CW'(COUNT_LIMIT)) && (cnt_z_q >= -CW'(COUNT_LIMIT)))
		else $error("motion counter outside limit");

	a_one_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> $onehot0({gesture_z_s2, gesture_x_s2, gesture_y_s2}))
		else $error("more than one gesture in a beat");

	a_gesture_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (gesture_z_s2 || gesture_x_s2 || gesture_y_s2)) |->
		((!gesture_z_s2 || count_z_s2 == '0) && (!gesture_x_s2 || count_x_s2 == '0)
		&& (!gesture_y_s2 || count_y_s2 == '0)))
		else $error("gesture axis counter not cleared");

	a_state_matches_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (moving_x_s2 == flag_x_q) && (moving_y_s2 == flag_y_q)
		&& (moving_z_s2 == flag_z_q))
		else $error("result flags differ from held state");
`endif

endmodule
